>>> rtl/core/button_packet_command_decoder_unit_macros.svh
// Shared assertion macros for the button packet decoder checks
`ifndef BUTTON_PACKET_COMMAND_DECODER_UNIT_MACROS_SVH
`define BUTTON_PACKET_COMMAND_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define BPCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpcd check failed");

// Next-cycle implication, off while reset is held
`define BPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpcd check failed");

`endif

>>> rtl/core/bpcd_pkg.sv
package bpcd_pkg;

    // Command kinds on the result port
    localparam logic [1:0] KIND_DRIVE  = 2'd0;
    localparam logic [1:0] KIND_TURRET = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURRET_STEP = 2'd1;

    // Reset values of the configuration registers
    localparam logic [6:0]  DRIVE_MAG_RST   = 7'd64;
    localparam logic [15:0] TURRET_STEP_RST = 16'd25000;

    // Packet bytes
    localparam logic [7:0] CHR_BANG  = 8'h21;
    localparam logic [7:0] CHR_B     = 8'h42;
    localparam logic [7:0] CHR_PRESS = 8'h31;
    localparam logic [7:0] BTN_1     = 8'h31;
    localparam logic [7:0] BTN_2     = 8'h32;
    localparam logic [7:0] BTN_3     = 8'h33;
    localparam logic [7:0] BTN_5     = 8'h35;
    localparam logic [7:0] BTN_6     = 8'h36;
    localparam logic [7:0] BTN_7     = 8'h37;
    localparam logic [7:0] BTN_8     = 8'h38;

    // Decoded operations passed from the parser to the executor
    typedef enum logic [2:0] {
        OP_TURRET_NEG = 3'd0,
        OP_TURRET_POS = 3'd1,
        OP_FIRE       = 3'd2,
        OP_DRV_FWD    = 3'd3,
        OP_DRV_REV    = 3'd4,
        OP_DRV_LEFT   = 3'd5,
        OP_DRV_RIGHT  = 3'd6
    } t_op;

    // One queued command
    typedef struct packed {
        t_op  op;
        logic pressed;
    } t_cmd;

endpackage

>>> rtl/core/bpcd_fifo.sv
module bpcd_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bpcd_pkg::t_cmd i_data,
    input  logic           i_pop,
    output bpcd_pkg::t_cmd o_data,
    output logic           o_empty,
    output logic           o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bpcd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           w_push, w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && !o_empty;

    // Advance pointers with explicit wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the word being pushed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/bpcd_front.sv
module bpcd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_q_full,
    output logic           o_push,
    output bpcd_pkg::t_cmd o_cmd
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BANG = 3'd1;
    localparam logic [2:0] PH_B    = 3'd2;
    localparam logic [2:0] PH_NUM  = 3'd3;
    localparam logic [2:0] PH_HIT  = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_button, n_button;
    logic [7:0]       r_press, n_press;
    logic             w_accept;
    logic [7:0]       w_check;
    logic             w_known;
    bpcd_pkg::t_op    w_op;

    // Only the check byte needs room in the queue
    assign o_ready  = (r_phase != PH_HIT) || !i_q_full;
    assign w_accept = i_valid && o_ready;

    // Expected check byte: inverse of the header sum
    assign w_check = ~(bpcd_pkg::CHR_BANG + bpcd_pkg::CHR_B + r_button + r_press);

    // Classify the button number
    always_comb begin
        w_known = 1'b1;
        w_op    = bpcd_pkg::OP_FIRE;
        unique case (r_button)
            bpcd_pkg::BTN_1: w_op = bpcd_pkg::OP_TURRET_NEG;
            bpcd_pkg::BTN_2: w_op = bpcd_pkg::OP_TURRET_POS;
            bpcd_pkg::BTN_3: w_op = bpcd_pkg::OP_FIRE;
            bpcd_pkg::BTN_5: w_op = bpcd_pkg::OP_DRV_FWD;
            bpcd_pkg::BTN_6: w_op = bpcd_pkg::OP_DRV_REV;
            bpcd_pkg::BTN_7: w_op = bpcd_pkg::OP_DRV_LEFT;
            bpcd_pkg::BTN_8: w_op = bpcd_pkg::OP_DRV_RIGHT;
            default:         w_known = 1'b0;
        endcase
    end

    assign o_cmd.op      = w_op;
    assign o_cmd.pressed = (r_press == bpcd_pkg::CHR_PRESS);
    assign o_push        = w_accept && (r_phase == PH_HIT) &&
                           (i_rx_byte == w_check) && w_known;

    // Step the parser on each accepted word
    always_comb begin
        n_phase  = r_phase;
        n_button = r_button;
        n_press  = r_press;
        if (w_accept) begin
            unique case (r_phase)
                PH_BANG: n_phase = (i_rx_byte == bpcd_pkg::CHR_B) ? PH_B : PH_IDLE;
                PH_B: begin
                    n_button = i_rx_byte;
                    n_phase  = PH_NUM;
                end
                PH_NUM: begin
                    n_press = i_rx_byte;
                    n_phase = PH_HIT;
                end
                PH_HIT:  n_phase = PH_IDLE;
                default: n_phase = (i_rx_byte == bpcd_pkg::CHR_BANG) ? PH_BANG : PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_button <= '0;
            r_press  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_button <= n_button;
            r_press  <= n_press;
        end
    end

endmodule

>>> rtl/core/bpcd_back.sv
module bpcd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  bpcd_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    input  logic [6:0]         i_drive_magnitude,
    input  logic [15:0]        i_turret_step_ns,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_command_kind,
    output logic signed [7:0]  o_left_speed,
    output logic signed [7:0]  o_right_speed,
    output logic signed [16:0] o_turret_delta_ns,
    output logic               o_fire_pressed
);

    logic               r_valid;
    logic [1:0]         r_kind, n_kind;
    logic signed [7:0]  r_left, n_left;
    logic signed [7:0]  r_right, n_right;
    logic signed [16:0] r_delta, n_delta;
    logic               r_fire, n_fire;
    logic signed [7:0]  w_pos, w_neg;
    logic signed [16:0] w_step_pos, w_step_neg;

    // Take a command whenever the output register is free or draining
    assign o_pop = !i_q_empty && (!r_valid || i_ready);

    assign w_pos      = {1'b0, i_drive_magnitude};
    assign w_neg      = -w_pos;
    assign w_step_pos = {1'b0, i_turret_step_ns};
    assign w_step_neg = -w_step_pos;

    // Build the result fields; release leaves them zero
    always_comb begin
        n_kind  = bpcd_pkg::KIND_DRIVE;
        n_left  = '0;
        n_right = '0;
        n_delta = '0;
        n_fire  = 1'b0;
        unique case (i_cmd.op)
            bpcd_pkg::OP_TURRET_NEG: begin
                n_kind = bpcd_pkg::KIND_TURRET;
                if (i_cmd.pressed) n_delta = w_step_neg;
            end
            bpcd_pkg::OP_TURRET_POS: begin
                n_kind = bpcd_pkg::KIND_TURRET;
                if (i_cmd.pressed) n_delta = w_step_pos;
            end
            bpcd_pkg::OP_FIRE: begin
                n_kind = bpcd_pkg::KIND_FIRE;
                n_fire = i_cmd.pressed;
            end
            bpcd_pkg::OP_DRV_FWD: begin
                if (i_cmd.pressed) begin
                    n_left  = w_pos;
                    n_right = w_pos;
                end
            end
            bpcd_pkg::OP_DRV_REV: begin
                if (i_cmd.pressed) begin
                    n_left  = w_neg;
                    n_right = w_neg;
                end
            end
            bpcd_pkg::OP_DRV_LEFT: begin
                if (i_cmd.pressed) begin
                    n_left  = w_neg;
                    n_right = w_pos;
                end
            end
            bpcd_pkg::OP_DRV_RIGHT: begin
                if (i_cmd.pressed) begin
                    n_left  = w_pos;
                    n_right = w_neg;
                end
            end
            default: n_kind = bpcd_pkg::KIND_DRIVE;
        endcase
    end

    // Output valid: set on pop, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_right <= n_right;
            r_delta <= n_delta;
            r_fire  <= n_fire;
        end
    end

    assign o_valid           = r_valid;
    assign o_command_kind    = r_kind;
    assign o_left_speed      = r_left;
    assign o_right_speed     = r_right;
    assign o_turret_delta_ns = r_delta;
    assign o_fire_pressed    = r_fire;

endmodule

>>> rtl/core/button_packet_command_decoder_unit.sv
// Button packet command decoder.
// Input channel (i_valid / o_ready / i_rx_byte) takes one received serial byte
// per word and parses five-byte packets: '!', 'B', button, press, check byte.
// A packet with a good check byte and a known button gives one result word on
// the output channel (o_valid / i_ready): command kind, wheel speeds, turret
// step or fire flag, with unused fields zero.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
// writes index 0 drive magnitude (data bits 6:0) or index 1 turret step
// (data bits 15:0); other indexes are ignored. Write only while idle.
// Throughput: one byte per cycle while o_ready is high. The parser front end
// pushes a decoded command into a small queue, and the executor back end pops
// it into the output register. A command enters the queue at the edge that
// accepts its check byte, and is popped when the output register is free or taken.
// When the receiver stalls, results collect in the queue; the input keeps
// taking bytes and holds off only a check byte that finds the queue full.
// Reset (synchronous, active low) returns the parser to idle, empties the
// queue and output register, and reloads both configuration registers.
module button_packet_command_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_rx_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_command_kind,
    output logic signed [7:0]                o_left_speed,
    output logic signed [7:0]                o_right_speed,
    output logic signed [16:0]               o_turret_delta_ns,
    output logic                             o_fire_pressed,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bpcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);

    logic [6:0]     r_drive_magnitude;
    logic [15:0]    r_turret_step_ns;
    logic           w_push, w_pop, w_q_empty, w_q_full;
    bpcd_pkg::t_cmd w_push_cmd, w_pop_cmd;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_magnitude <= bpcd_pkg::DRIVE_MAG_RST;
            r_turret_step_ns  <= bpcd_pkg::TURRET_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpcd_pkg::CFG_DRIVE_MAG:   r_drive_magnitude <= i_cfg_data[6:0];
                bpcd_pkg::CFG_TURRET_STEP: r_turret_step_ns  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser front end
    bpcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // Command queue
    bpcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_pop_cmd),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // Executor back end
    bpcd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_q_empty),
        .i_cmd             (w_pop_cmd),
        .o_pop             (w_pop),
        .i_drive_magnitude (r_drive_magnitude),
        .i_turret_step_ns  (r_turret_step_ns),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_command_kind    (o_command_kind),
        .o_left_speed      (o_left_speed),
        .o_right_speed     (o_right_speed),
        .o_turret_delta_ns (o_turret_delta_ns),
        .o_fire_pressed    (o_fire_pressed)
    );

endmodule

>>> rtl/core/bpcd_checker.sv
`include "button_packet_command_decoder_unit_macros.svh"

module bpcd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [1:0]                     o_command_kind,
    input logic signed [7:0]              o_left_speed,
    input logic signed [7:0]              o_right_speed,
    input logic signed [16:0]             o_turret_delta_ns,
    input logic                           o_fire_pressed
);

    // Hold a stalled result
    `BPCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // Kind code stays in range
    `BPCD_ASSERT_IMPLY(a_kind_range, i_clk, i_rst_n, o_valid, o_command_kind != 2'd3)

    // Fields outside the command kind read zero
    `BPCD_ASSERT_IMPLY(a_zero_fields, i_clk, i_rst_n, o_valid,
        ((o_command_kind == bpcd_pkg::KIND_DRIVE) ||
         (o_left_speed == '0 && o_right_speed == '0)) &&
        ((o_command_kind == bpcd_pkg::KIND_TURRET) || (o_turret_delta_ns == '0)) &&
        ((o_command_kind == bpcd_pkg::KIND_FIRE) || !o_fire_pressed))

    // A fresh result follows an accepted input word
    `BPCD_ASSERT_IMPLY(a_rise_after_accept, i_clk, i_rst_n, $rose(o_valid),
        $past(i_valid && o_ready, 2))

endmodule

bind button_packet_command_decoder_unit bpcd_checker u_bpcd_checker (.*);

>>> tb/sv/button_packet_command_decoder_unit_tb.sv
module button_packet_command_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that decode to nothing
    localparam logic [bpcd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [bpcd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    // Button number with no command behind it
    localparam logic [7:0] BTN_UNUSED = 8'h34;

    localparam int unsigned LATENCY_PAD  = 8;
    localparam int unsigned HOLD_CYCLES  = 90;
    localparam int unsigned PHASE_BYTES  = 155;
    localparam int unsigned PHASE_COUNT  = 10;

    // Parser position after each byte
    typedef enum logic [2:0] {
        PS_IDLE   = 3'd0,
        PS_BANG   = 3'd1,
        PS_HEAD   = 3'd2,
        PS_BUTTON = 3'd3,
        PS_PRESS  = 3'd4
    } t_parse;

    // One command word as seen on the result port
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [7:0]  left;
        logic signed [7:0]  right;
        logic signed [16:0] turret_ns;
        logic               fire;
    } t_cmd_word;

    class cmd_scoreboard;
        logic [6:0]  drive_mag;
        logic [15:0] turret_step;
        t_parse      phase;
        logic [7:0]  btn;
        logic [7:0]  press;
        t_cmd_word   due_q[$];
        int unsigned errors;
        int unsigned bytes_seen;
        int unsigned cmds_seen;
        int unsigned cfg_writes;
        int unsigned kind_seen[3];

        function new();
            drive_mag   = bpcd_pkg::DRIVE_MAG_RST;
            turret_step = bpcd_pkg::TURRET_STEP_RST;
            phase       = PS_IDLE;
            btn         = 8'd0;
            press       = 8'd0;
        endfunction

        static function logic [7:0] check_byte(logic [7:0] b, logic [7:0] p);
            return ~(bpcd_pkg::CHR_BANG + bpcd_pkg::CHR_B + b + p);
        endfunction

        function void write_reg(logic [bpcd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            cfg_writes++;
            if (idx == bpcd_pkg::CFG_DRIVE_MAG) drive_mag = data[6:0];
            else if (idx == bpcd_pkg::CFG_TURRET_STEP) turret_step = data;
        endfunction

        // Build the command for the held button and press bytes
        function bit decode(output t_cmd_word c);
            logic        on;
            logic [7:0]  m;
            logic [7:0]  mn;
            logic [16:0] s;
            on = (press == bpcd_pkg::CHR_PRESS);
            m  = on ? {1'b0, drive_mag} : 8'd0;
            mn = 8'd0 - m;
            s  = on ? {1'b0, turret_step} : 17'd0;
            c  = '0;
            case (btn)
                bpcd_pkg::BTN_1: begin
                    c.kind = bpcd_pkg::KIND_TURRET;
                    c.turret_ns = 17'd0 - s;
                end
                bpcd_pkg::BTN_2: begin
                    c.kind = bpcd_pkg::KIND_TURRET;
                    c.turret_ns = s;
                end
                bpcd_pkg::BTN_3: begin
                    c.kind = bpcd_pkg::KIND_FIRE;
                    c.fire = on;
                end
                bpcd_pkg::BTN_5: begin
                    c.kind = bpcd_pkg::KIND_DRIVE;
                    c.left = m;
                    c.right = m;
                end
                bpcd_pkg::BTN_6: begin
                    c.kind = bpcd_pkg::KIND_DRIVE;
                    c.left = mn;
                    c.right = mn;
                end
                bpcd_pkg::BTN_7: begin
                    c.kind = bpcd_pkg::KIND_DRIVE;
                    c.left = mn;
                    c.right = m;
                end
                bpcd_pkg::BTN_8: begin
                    c.kind = bpcd_pkg::KIND_DRIVE;
                    c.left = m;
                    c.right = mn;
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // Advance the parser on one accepted byte; queue a command on a good packet
        function void note_byte(logic [7:0] b);
            t_cmd_word c;
            bytes_seen++;
            case (phase)
                PS_BANG: phase = (b == bpcd_pkg::CHR_B) ? PS_HEAD : PS_IDLE;
                PS_HEAD: begin
                    btn = b;
                    phase = PS_BUTTON;
                end
                PS_BUTTON: begin
                    press = b;
                    phase = PS_PRESS;
                end
                PS_PRESS: begin
                    phase = PS_IDLE;
                    if (b == check_byte(btn, press) && decode(c)) due_q.push_back(c);
                end
                default: phase = (b == bpcd_pkg::CHR_BANG) ? PS_BANG : PS_IDLE;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one result word against the oldest pending command
        task check_command(t_cmd_word got);
            t_cmd_word want;
            if (due_q.size() == 0) begin
                report_mismatch($sformatf("result word kind %0d with no command pending",
                                          got.kind));
                return;
            end
            want = due_q.pop_front();
            cmds_seen++;
            if (want.kind < 3) kind_seen[want.kind]++;
            if (got.kind !== want.kind)
                report_mismatch($sformatf("command_kind got %0d want %0d",
                                          got.kind, want.kind));
            if (got.left !== want.left)
                report_mismatch($sformatf("left_speed got %0d want %0d",
                                          got.left, want.left));
            if (got.right !== want.right)
                report_mismatch($sformatf("right_speed got %0d want %0d",
                                          got.right, want.right));
            if (got.turret_ns !== want.turret_ns)
                report_mismatch($sformatf("turret_delta_ns got %0d want %0d",
                                          got.turret_ns, want.turret_ns));
            if (got.fire !== want.fire)
                report_mismatch($sformatf("fire_pressed got %0b want %0b",
                                          got.fire, want.fire));
        endtask
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_ready;
    logic [7:0]                           i_rx_byte;
    logic                                 o_valid;
    logic                                 i_ready;
    logic [1:0]                           o_command_kind;
    logic signed [7:0]                    o_left_speed;
    logic signed [7:0]                    o_right_speed;
    logic signed [16:0]                   o_turret_delta_ns;
    logic                                 o_fire_pressed;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [bpcd_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [15:0]                          i_cfg_data;

    cmd_scoreboard sb;
    bit            no_idle;
    bit            hold_req;
    int unsigned   in_stall_cycles;

    button_packet_command_decoder_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_command_kind    (o_command_kind),
        .o_left_speed      (o_left_speed),
        .o_right_speed     (o_right_speed),
        .o_turret_delta_ns (o_turret_delta_ns),
        .o_fire_pressed    (o_fire_pressed),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the whole run as failed after a generous bound
    initial begin
        #2_000_000;
        $display("timeout with %0d commands still pending", sb.due_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: take words, check them, and drop ready at random or on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_command({o_command_kind, o_left_speed, o_right_speed,
                                  o_turret_delta_ns, o_fire_pressed});
            if (i_rst_n && i_valid && !o_ready) in_stall_cycles++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= no_idle || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    // Offer one byte and hold it until the block takes it
    task automatic send_byte(logic [7:0] b);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    // Send one byte, then idle a cycle now and then
    task automatic put_byte(logic [7:0] b);
        send_byte(b);
        if (!no_idle && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_frame(logic [7:0] btn, logic [7:0] press, logic [7:0] chk);
        put_byte(bpcd_pkg::CHR_BANG);
        put_byte(bpcd_pkg::CHR_B);
        put_byte(btn);
        put_byte(press);
        put_byte(chk);
    endtask

    function automatic logic [7:0] pick_button();
        case ($urandom_range(0, 6))
            0: return bpcd_pkg::BTN_1;
            1: return bpcd_pkg::BTN_2;
            2: return bpcd_pkg::BTN_3;
            3: return bpcd_pkg::BTN_5;
            4: return bpcd_pkg::BTN_6;
            5: return bpcd_pkg::BTN_7;
            default: return bpcd_pkg::BTN_8;
        endcase
    endfunction

    // Mostly good packets; unknown buttons, bad checks, broken or cut heads, noise
    task automatic send_random_frame();
        int unsigned pick;
        logic [7:0]  btn;
        logic [7:0]  press;
        logic [7:0]  b;
        pick  = $urandom_range(0, 99);
        btn   = pick_button();
        press = ($urandom_range(0, 1) != 0) ? bpcd_pkg::CHR_PRESS
                                             : 8'($urandom_range(0, 255));
        if (pick < 70) begin
            send_frame(btn, press, cmd_scoreboard::check_byte(btn, press));
        end else if (pick < 80) begin
            btn = 8'($urandom_range(0, 255));
            while (btn inside {bpcd_pkg::BTN_1, bpcd_pkg::BTN_2, bpcd_pkg::BTN_3,
                               bpcd_pkg::BTN_5, bpcd_pkg::BTN_6, bpcd_pkg::BTN_7,
                               bpcd_pkg::BTN_8})
                btn = 8'($urandom_range(0, 255));
            send_frame(btn, press, cmd_scoreboard::check_byte(btn, press));
        end else if (pick < 88) begin
            send_frame(btn, press,
                       cmd_scoreboard::check_byte(btn, press) ^ (8'd1 << $urandom_range(0, 7)));
        end else if (pick < 94) begin
            b = 8'($urandom_range(0, 255));
            if (b == bpcd_pkg::CHR_B) b = bpcd_pkg::CHR_BANG;
            put_byte(bpcd_pkg::CHR_BANG);
            put_byte(b);
        end else if (pick < 97) begin
            put_byte(bpcd_pkg::CHR_BANG);
            put_byte(bpcd_pkg::CHR_B);
            put_byte(btn);
        end else begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic cfg_write(logic [bpcd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Load the register setting for one phase of the run
    task automatic apply_setting(int unsigned p);
        case (p)
            0: ;
            1: begin
                cfg_write(bpcd_pkg::CFG_DRIVE_MAG, 16'h0000);
                cfg_write(bpcd_pkg::CFG_TURRET_STEP, 16'h0000);
            end
            2: begin
                cfg_write(bpcd_pkg::CFG_DRIVE_MAG, 16'h007F);
                cfg_write(bpcd_pkg::CFG_TURRET_STEP, 16'hFFFF);
            end
            3: begin
                cfg_write(bpcd_pkg::CFG_DRIVE_MAG, 16'hFF81);
                cfg_write(bpcd_pkg::CFG_TURRET_STEP, 16'h0001);
                cfg_write(CFG_IDX_SPARE_A, 16'hFFFF);
                cfg_write(CFG_IDX_SPARE_B, 16'h0000);
            end
            default: begin
                cfg_write(bpcd_pkg::CFG_DRIVE_MAG, 16'($urandom));
                cfg_write(bpcd_pkg::CFG_TURRET_STEP, 16'($urandom));
                cfg_write(CFG_IDX_SPARE_A, 16'($urandom));
                cfg_write(CFG_IDX_SPARE_B, 16'($urandom));
            end
        endcase
        if (p != 0) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every pending command has come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        drain();
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    initial begin
        int unsigned start;
        bit          paused;
        sb = new();
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        in_stall_cycles = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_rx_byte   <= 8'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= bpcd_pkg::CFG_DRIVE_MAG;
        i_cfg_data  <= 16'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, a repeated start byte, good, released,
        // bad-check and unknown-button packets
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(bpcd_pkg::CHR_BANG);
        put_byte(bpcd_pkg::CHR_BANG);
        put_byte(bpcd_pkg::CHR_B);
        send_frame(bpcd_pkg::BTN_5, bpcd_pkg::CHR_PRESS,
                   cmd_scoreboard::check_byte(bpcd_pkg::BTN_5, bpcd_pkg::CHR_PRESS));
        send_frame(bpcd_pkg::BTN_3, 8'hFF,
                   cmd_scoreboard::check_byte(bpcd_pkg::BTN_3, 8'hFF));
        send_frame(bpcd_pkg::BTN_1, bpcd_pkg::CHR_PRESS,
                   ~cmd_scoreboard::check_byte(bpcd_pkg::BTN_1, bpcd_pkg::CHR_PRESS));
        send_frame(BTN_UNUSED, bpcd_pkg::CHR_PRESS,
                   cmd_scoreboard::check_byte(BTN_UNUSED, bpcd_pkg::CHR_PRESS));
        wait_idle();

        // Random phases, each under its own register setting
        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            apply_setting(p);
            no_idle = (p == 5);
            paused  = 1'b0;
            start   = sb.bytes_seen;
            if (p == 3) begin
                // Stall the result side while packets keep coming at full rate
                no_idle  = 1'b1;
                hold_req = 1'b1;
                repeat (12) send_random_frame();
                no_idle  = 1'b0;
            end
            while (sb.bytes_seen - start < PHASE_BYTES) begin
                if (p == 7 && !paused && sb.bytes_seen - start >= PHASE_BYTES / 2) begin
                    paused = 1'b1;
                    drain();
                end
                send_random_frame();
            end
            wait_idle();
        end

        $display("Covered %0d bytes, %0d commands (drive %0d, turret %0d, fire %0d),",
                 sb.bytes_seen, sb.cmds_seen, sb.kind_seen[bpcd_pkg::KIND_DRIVE],
                 sb.kind_seen[bpcd_pkg::KIND_TURRET], sb.kind_seen[bpcd_pkg::KIND_FIRE]);
        $display("%0d register writes, %0d cycles of input back-pressure, %0d mismatches.",
                 sb.cfg_writes, in_stall_cycles, sb.errors);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bpcd_pkg.sv
rtl/core/bpcd_fifo.sv
rtl/core/bpcd_front.sv
rtl/core/bpcd_back.sv
rtl/core/button_packet_command_decoder_unit.sv
rtl/core/bpcd_checker.sv
tb/sv/button_packet_command_decoder_unit_tb.sv
